// ===== rtl/bez_pkg.sv =====
// Shared types and constants for the cubic Bezier flattener.
`timescale 1ns / 1ps
`default_nettype none

package bez_pkg;

    localparam int CURVE_POINTS_DEF = 51;

    localparam int COORD_W  = 12;
    localparam int COLOUR_W = 16;
    localparam int WEIGHT_W = 16;                   // Q1.15, reaches 32768
    localparam int PROD_W   = WEIGHT_W + COORD_W;   // one weight times one coordinate
    localparam int SUM_W    = PROD_W + 2;           // four products
    localparam int FRAC_W   = 15;
    localparam int NUM_PTS  = 8;                    // x0,y0,x1,y1,x2,y2,x3,y3

    localparam logic [COORD_W-1:0] COORD_MAX = '1;
    localparam logic [SUM_W-1:0]   ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);

    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [COLOUR_W-1:0] colour_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef coord_t  [NUM_PTS-1:0] ctrl_pts_t;
    typedef weight_t [3:0]         weight_set_t;
    typedef logic [PROD_W-1:0]   prod_t;
    typedef logic [SUM_W-1:0]    sum_t;

    // control that travels with each point through the pipe
    typedef struct packed {
        logic    valid;
        logic    first;
        logic    last;
        colour_t colour;
    } tag_t;

endpackage

`default_nettype wire

// ===== rtl/bez_curve_if.sv =====
// Input channel: one curve (four control points and a colour) per word.
`timescale 1ns / 1ps
`default_nettype none

interface bez_curve_if;
    import bez_pkg::*;

    logic    valid;
    logic    ready;
    coord_t  start_x;
    coord_t  start_y;
    coord_t  pull_one_x;
    coord_t  pull_one_y;
    coord_t  pull_two_x;
    coord_t  pull_two_y;
    coord_t  finish_x;
    coord_t  finish_y;
    colour_t colour_in;

    modport source (
        output valid, start_x, start_y, pull_one_x, pull_one_y,
               pull_two_x, pull_two_y, finish_x, finish_y, colour_in,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, pull_one_x, pull_one_y,
               pull_two_x, pull_two_y, finish_x, finish_y, colour_in,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/bez_seg_if.sv =====
// Output channel: one line segment per word.
`timescale 1ns / 1ps
`default_nettype none

interface bez_seg_if;
    import bez_pkg::*;

    logic    valid;
    logic    ready;
    coord_t  from_x;
    coord_t  from_y;
    coord_t  to_x;
    coord_t  to_y;
    colour_t colour_out;
    logic    last_segment;

    modport source (
        output valid, from_x, from_y, to_x, to_y, colour_out, last_segment,
        input  ready
    );

    modport sink (
        input  valid, from_x, from_y, to_x, to_y, colour_out, last_segment,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/bez_seq.sv =====
// Step sequencer: holds one curve, walks t = k/N and looks up Bernstein weights.
`timescale 1ns / 1ps
`default_nettype none

module bez_seq
    import bez_pkg::*;
#(
    parameter int CURVE_POINTS = CURVE_POINTS_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    bez_curve_if.sink   curve,
    input  wire         adv,
    output logic        busy,
    output logic [$clog2(CURVE_POINTS)-1:0] step,
    output ctrl_pts_t   pts,
    output weight_set_t weights,
    output tag_t        tag
);

    localparam int KW = $clog2(CURVE_POINTS);
    localparam logic [KW-1:0] LAST_K = KW'(CURVE_POINTS - 1);
    localparam longint unsigned N  = longint'(CURVE_POINTS - 1);
    localparam longint unsigned N3 = N * N * N;

    // weight table, worked out at elaboration
    weight_set_t w_tab [CURVE_POINTS];

    for (genvar k = 0; k < CURVE_POINTS; k++) begin : g_wtab
        localparam longint unsigned KK = longint'(k);
        localparam longint unsigned A  = N - KK;
        localparam longint unsigned W0 = (A * A * A * 32768 + N3 / 2) / N3;
        localparam longint unsigned W1 = (3 * A * A * KK * 32768 + N3 / 2) / N3;
        localparam longint unsigned W2 = (3 * A * KK * KK * 32768 + N3 / 2) / N3;
        localparam longint unsigned W3 = (KK * KK * KK * 32768 + N3 / 2) / N3;
        assign w_tab[k][0] = WEIGHT_W'(W0);
        assign w_tab[k][1] = WEIGHT_W'(W1);
        assign w_tab[k][2] = WEIGHT_W'(W2);
        assign w_tab[k][3] = WEIGHT_W'(W3);
    end

    logic      busy_reg;
    logic [KW-1:0] k_reg;
    ctrl_pts_t held_pts_reg;
    colour_t   held_colour_reg;
    ctrl_pts_t pts_reg;
    weight_set_t w_reg;
    tag_t      tag_reg;

    logic accept;
    logic issue;
    logic at_last;

    assign at_last     = (k_reg == LAST_K);
    assign issue       = busy_reg && adv;
    // the next curve may load on the edge that issues the final step
    assign curve.ready = !busy_reg || (adv && at_last);
    assign accept      = curve.valid && curve.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
            tag_reg  <= '0;
        end
        else
        begin
            if (adv)
            begin
                tag_reg.valid  <= busy_reg;
                tag_reg.first  <= (k_reg == '0);
                tag_reg.last   <= at_last;
                tag_reg.colour <= held_colour_reg;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (issue)
            begin
                if (at_last)
                begin
                    busy_reg <= 1'b0;
                    k_reg    <= '0;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_pts_reg[0] <= curve.start_x;
            held_pts_reg[1] <= curve.start_y;
            held_pts_reg[2] <= curve.pull_one_x;
            held_pts_reg[3] <= curve.pull_one_y;
            held_pts_reg[4] <= curve.pull_two_x;
            held_pts_reg[5] <= curve.pull_two_y;
            held_pts_reg[6] <= curve.finish_x;
            held_pts_reg[7] <= curve.finish_y;
            held_colour_reg <= curve.colour_in;
        end
        if (issue)
        begin
            pts_reg <= held_pts_reg;
            w_reg   <= w_tab[k_reg];
        end
    end

    assign busy    = busy_reg;
    assign step    = k_reg;
    assign pts     = pts_reg;
    assign weights = w_reg;
    assign tag     = tag_reg;

endmodule

`default_nettype wire

// ===== rtl/bez_mac.sv =====
// Weighted sum: eight products in one stage, two four-term sums in the next.
`timescale 1ns / 1ps
`default_nettype none

module bez_mac
    import bez_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         adv,
    input  ctrl_pts_t   pts,
    input  weight_set_t weights,
    input  tag_t        tag_in,
    output sum_t        sum_x,
    output sum_t        sum_y,
    output tag_t        tag_out
);

    prod_t prod_reg [NUM_PTS];
    tag_t  tag_b_reg;
    sum_t  sum_x_reg;
    sum_t  sum_y_reg;
    tag_t  tag_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end
        else if (adv)
        begin
            tag_b_reg <= tag_in;
            tag_c_reg <= tag_b_reg;
        end
    end

    // products for point i: x uses pts[2i], y uses pts[2i+1]
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NUM_PTS; i++)
            begin
                prod_reg[i] <= PROD_W'(weights[i / 2]) * PROD_W'(pts[i]);
            end
            sum_x_reg <= SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[2])
                       + SUM_W'(prod_reg[4]) + SUM_W'(prod_reg[6]);
            sum_y_reg <= SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[3])
                       + SUM_W'(prod_reg[5]) + SUM_W'(prod_reg[7]);
        end
    end

    assign sum_x   = sum_x_reg;
    assign sum_y   = sum_y_reg;
    assign tag_out = tag_c_reg;

endmodule

`default_nettype wire

// ===== rtl/bez_round.sv =====
// Round to Q8.4, saturate, join consecutive points into segments, output register.
`timescale 1ns / 1ps
`default_nettype none

module bez_round
    import bez_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  sum_t       sum_x,
    input  sum_t       sum_y,
    input  tag_t       tag_in,
    output logic       adv,
    bez_seg_if.source  seg
);

    localparam int RND_W = SUM_W + 1 - FRAC_W;

    logic    valid_reg;
    coord_t  from_x_reg;
    coord_t  from_y_reg;
    coord_t  to_x_reg;
    coord_t  to_y_reg;
    colour_t colour_reg;
    logic    last_reg;

    logic [SUM_W:0]   rx_full;
    logic [SUM_W:0]   ry_full;
    logic [RND_W-1:0] rx;
    logic [RND_W-1:0] ry;
    coord_t           to_x_next;
    coord_t           to_y_next;

    assign adv = !valid_reg || seg.ready;

    always_comb
    begin
        rx_full   = {1'b0, sum_x} + {1'b0, ROUND_HALF};
        ry_full   = {1'b0, sum_y} + {1'b0, ROUND_HALF};
        rx        = rx_full[SUM_W:FRAC_W];
        ry        = ry_full[SUM_W:FRAC_W];
        // rounded weights can sum past one
        to_x_next = (rx > RND_W'(COORD_MAX)) ? COORD_MAX : rx[COORD_W-1:0];
        to_y_next = (ry > RND_W'(COORD_MAX)) ? COORD_MAX : ry[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= tag_in.valid;
        end
    end

    // to_*_reg keeps the previous point across bubbles
    always_ff @(posedge clk)
    begin
        if (adv && tag_in.valid)
        begin
            from_x_reg <= tag_in.first ? to_x_next : to_x_reg;
            from_y_reg <= tag_in.first ? to_y_next : to_y_reg;
            to_x_reg   <= to_x_next;
            to_y_reg   <= to_y_next;
            colour_reg <= tag_in.colour;
            last_reg   <= tag_in.last;
        end
    end

    assign seg.valid        = valid_reg;
    assign seg.from_x       = from_x_reg;
    assign seg.from_y       = from_y_reg;
    assign seg.to_x         = to_x_reg;
    assign seg.to_y         = to_y_reg;
    assign seg.colour_out   = colour_reg;
    assign seg.last_segment = last_reg;

endmodule

`default_nettype wire

// ===== rtl/cubic_bezier_flattener.sv =====
// Top level of the cubic Bezier flattener.
`timescale 1ns / 1ps
`default_nettype none

// Takes one cubic Bezier curve per input word (four Q8.4 control points and an
// RGB565 colour) and emits CURVE_POINTS line segments (51 by default), one per point of
// t = k/(CURVE_POINTS-1), each from the previous curve point to the current one;
// the first segment has zero length at the start point, the last carries
// last_segment. Points use Q1.15 Bernstein weights, round half up and saturate
// at 4095. The step sequencer issues one point per cycle unless output back-pressure
// holds it, and the next curve is taken on the cycle its predecessor issues its
// final point. A point passes the weight lookup, product, sum and rounding output
// registers in that order before it leaves as a segment. Output back-pressure
// stalls the whole pipe.
module cubic_bezier_flattener
    import bez_pkg::*;
#(
    parameter int CURVE_POINTS = CURVE_POINTS_DEF
)
(
    input  wire        clk,
    input  wire        rst_n,
    bez_curve_if.sink  curve,
    bez_seg_if.source  seg
);

    localparam int KW = $clog2(CURVE_POINTS);

    logic          adv;
    logic          busy;
    logic [KW-1:0] step;
    ctrl_pts_t     pts;
    weight_set_t   weights;
    tag_t          tag_a;
    tag_t          tag_c;
    sum_t          sum_x;
    sum_t          sum_y;

    bez_seq #(
        .CURVE_POINTS (CURVE_POINTS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .curve   (curve),
        .adv     (adv),
        .busy    (busy),
        .step    (step),
        .pts     (pts),
        .weights (weights),
        .tag     (tag_a)
    );

    bez_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .pts     (pts),
        .weights (weights),
        .tag_in  (tag_a),
        .sum_x   (sum_x),
        .sum_y   (sum_y),
        .tag_out (tag_c)
    );

    bez_round u_round (
        .clk    (clk),
        .rst_n  (rst_n),
        .sum_x  (sum_x),
        .sum_y  (sum_y),
        .tag_in (tag_c),
        .adv    (adv),
        .seg    (seg)
    );

    // a freshly taken curve closes the input in the following cycle
    a_hold_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        curve.valid && curve.ready |=> !curve.ready)
        else $error("input reopened right after taking a curve");

    a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (step == '0) && curve.ready)
        else $error("idle sequencer with nonzero step or closed input");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step <= KW'(CURVE_POINTS - 1))
        else $error("step index past the last curve point");

endmodule

`default_nettype wire
